/* design/pds_pkg.sv */
// Package for the process dispatch scheduler: request, status and policy codes.
// No dependencies.
package pds_pkg;
   localparam int DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF = 16;
   localparam int ID_W = 16;
   localparam int RANK_W = 8;
   localparam int FIELD_W = 16;

   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_DISPATCH = 2'd1;

   localparam logic [2:0] ST_ADDED = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_RUN = 3'd2;
   localparam logic [2:0] ST_IDLE = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   localparam logic [2:0] POL_FCFS = 3'd0;
   localparam logic [2:0] POL_RR = 3'd1;
   localparam logic [2:0] POL_PRIO = 3'd2;
   localparam logic [2:0] POL_SJF = 3'd3;
   localparam logic [2:0] POL_SRTF = 3'd4;

   localparam logic CSR_POLICY = 1'b0;
   localparam logic CSR_QUANTUM = 1'b1;
endpackage

/* design/pds_cmp.sv */
// Shared key comparator of the scheduler: strict less-than with eligibility.
// Depends on pds_pkg.
module pds_cmp #(
   parameter int TIME_BITS = pds_pkg::TIME_BITS_DEF
) (
   input  logic [TIME_BITS-1:0] cand_key,
   input  logic [TIME_BITS-1:0] best_key,
   input  logic                 have_best,
   input  logic                 eligible,
   output logic                 take
);
   assign take = eligible && (!have_best || (cand_key < best_key));
endmodule

/* design/process_dispatch_scheduler_unit.sv */
// Process dispatch scheduler: a table of tasks with FCFS, RR, priority, SJF and SRTF.
// An add or restart is handled in the idle state. A dispatch scans one slot a cycle
// through the shared comparator, then shifts the table down one slot a cycle to remove
// or rotate. One item at a time.
// Synchronous active-high reset clears count, clock and output valid, and sets idle, FCFS, quantum 4.
// Depends on pds_pkg and pds_cmp.
module process_dispatch_scheduler_unit #(
   parameter int DEPTH = pds_pkg::DEPTH_DEF,
   parameter int TIME_BITS = pds_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata fields from bit 0: req_type[1:0], task_id[17:2], arrival_time[33:18],
   // burst_time[49:34], initial_remaining[65:50], task_priority[73:66], zero fill.
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata fields from bit 0: status[2:0], chosen_id[18:3], run_length[34:19],
   // finished[35], left_after[51:36], clock_now[67:52], zero fill.
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 2);
   localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
   localparam logic [CW-1:0] CDEPTH = CW'(DEPTH);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DEC = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   // Each table entry: id, arrival, burst, left, rank.
   typedef struct packed {
      logic [pds_pkg::ID_W-1:0]   id;
      logic [TIME_BITS-1:0]       arr;
      logic [TIME_BITS-1:0]       bur;
      logic [TIME_BITS-1:0]       lft;
      logic [pds_pkg::RANK_W-1:0] rank;
   } slot_type;

   slot_type table_mem [DEPTH];
   slot_type rd_ff;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           mode_ff;
   logic [15:0]          quantum_ff;
   logic [CW-1:0]        count_ff;
   logic [TIME_BITS-1:0] clk_ff;
   logic [CW-1:0]        ptr_ff;     // scan read address; rd_ff holds the slot before it
   logic                 rd_vld_ff;
   logic [IW-1:0]        pick_ff;
   logic                 have_ff;
   logic [TIME_BITS-1:0] best_ff;
   slot_type             hold_ff;    // chosen entry (kept for output, rotate and SRTF update)
   logic                 rotate_ff;
   logic [CW-1:0]        sh_ff;      // shift destination
   logic [71:0]          out_ff;
   logic                 outv_ff;

   logic [1:0] rtype;
   assign rtype = req_tdata[1:0];
   assign req_tready = (state_ff == S_IDLE) && !outv_ff;
   assign rsp_tvalid = outv_ff;
   assign rsp_tdata = out_ff;

   // Scan key under the current policy; SRTF also filters on arrival.
   logic [TIME_BITS-1:0] key;
   logic elig, take;
   always_comb begin
      case (mode_ff)
         pds_pkg::POL_PRIO: key = TIME_BITS'(rd_ff.rank);
         pds_pkg::POL_SJF:  key = rd_ff.bur;
         pds_pkg::POL_SRTF: key = rd_ff.lft;
         default:           key = '0;
      endcase
      elig = rd_vld_ff && ((mode_ff != pds_pkg::POL_SRTF) || (rd_ff.arr <= clk_ff));
   end

   pds_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
      .cand_key (key), .best_key(best_ff), .have_best(have_ff),
      .eligible (elig), .take(take)
   );

   function automatic logic [71:0] pack_out(logic [2:0] st, logic [15:0] id,
         logic [15:0] run, logic fin, logic [15:0] lf, logic [15:0] ck);
      return {4'd0, ck, lf, fin, run, id, st};
   endfunction

   logic [15:0] q16, ck16;
   assign q16 = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;
   assign ck16 = 16'(clk_ff);

   logic is_rr, is_srtf;
   assign is_rr = (mode_ff == pds_pkg::POL_RR);
   assign is_srtf = (mode_ff == pds_pkg::POL_SRTF);

   // The shift reads two slots ahead of the slot it writes, since read data is
   // registered; the decision cycle primes the first read at pick_ff+1.
   // The scan address is ptr_ff.
   logic [CW-1:0] raddr;
   assign raddr = (state_ff == S_SHIFT) ? sh_ff + CW'(2)
                : (state_ff == S_DEC) ? CW'(pick_ff) + CW'(1) : ptr_ff;

   // Table port: add at the tail, shift during removal or rotation, and the SRTF
   // partial update that writes the decremented remaining time back in place.
   always_ff @(posedge clock) begin
      if (raddr < CDEPTH) rd_ff <= table_mem[raddr[IW-1:0]];
      if (state_ff == S_IDLE && req_tvalid && req_tready && rtype == pds_pkg::REQ_ADD
            && count_ff < CDEPTH)
         table_mem[count_ff[IW-1:0]] <= '{id: req_tdata[17:2],
            arr: TIME_BITS'(req_tdata[33:18]), bur: TIME_BITS'(req_tdata[49:34]),
            lft: TIME_BITS'(req_tdata[65:50]), rank: req_tdata[73:66]};
      else if (state_ff == S_SHIFT) begin
         if (sh_ff + CW'(1) < count_ff) table_mem[sh_ff[IW-1:0]] <= rd_ff;
         else if (rotate_ff) table_mem[sh_ff[IW-1:0]] <= hold_ff;
      end
      else if (state_ff == S_OUT && have_ff && is_srtf && hold_ff.lft != '0)
         table_mem[pick_ff] <= hold_ff;
   end

   logic [TIME_BITS-1:0] run_t, left_t;
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid && req_tready && rtype == pds_pkg::REQ_DISPATCH
                     && count_ff != '0) state_in = S_SCAN;
         S_SCAN:  if (ptr_ff == count_ff) state_in = S_DEC;
         S_DEC:   state_in = S_SHIFT;
         S_SHIFT: if (sh_ff + CW'(1) >= count_ff) state_in = S_OUT;
         default: state_in = S_IDLE;
      endcase
      run_t = '0;
      left_t = '0;
      if (is_srtf) begin
         run_t = TIME_BITS'(1);
         left_t = (hold_ff.lft > TIME_BITS'(1)) ? hold_ff.lft - TIME_BITS'(1) : '0;
      end else if (is_rr) begin
         run_t = (hold_ff.lft < TIME_BITS'(q16)) ? hold_ff.lft : TIME_BITS'(q16);
         left_t = hold_ff.lft - run_t;
      end else run_t = hold_ff.lft;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= pds_pkg::POL_FCFS;
         quantum_ff <= 16'd4;
         count_ff <= '0;
         clk_ff <= '0;
         outv_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_addr == pds_pkg::CSR_POLICY) mode_ff <= csr_wdata[2:0];
            else quantum_ff <= csr_wdata;
         end
         if (outv_ff && rsp_tready) outv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               ptr_ff <= '0;
               rd_vld_ff <= 1'b0;
               have_ff <= 1'b0;
               pick_ff <= '0;
               if (rtype == pds_pkg::REQ_ADD) begin
                  outv_ff <= 1'b1;
                  if (count_ff < CDEPTH) begin
                     count_ff <= count_ff + CW'(1);
                     out_ff <= pack_out(pds_pkg::ST_ADDED, '0, '0, 1'b0, '0, ck16);
                  end else
                     out_ff <= pack_out(pds_pkg::ST_FULL, '0, '0, 1'b0, '0, ck16);
               end else if (rtype == pds_pkg::REQ_DISPATCH) begin
                  if (count_ff == '0) begin
                     outv_ff <= 1'b1;
                     out_ff <= pack_out(pds_pkg::ST_EMPTY, '0, '0, 1'b0, '0, ck16);
                  end
               end else begin
                  clk_ff <= '0;
                  outv_ff <= 1'b1;
                  out_ff <= pack_out(pds_pkg::ST_IDLE, '0, '0, 1'b0, '0, '0);
               end
            end
            S_SCAN: begin
               // rd_ff holds slot ptr_ff-1 when rd_vld_ff is set.
               if (take && !(have_ff && (is_rr || mode_ff == pds_pkg::POL_FCFS
                     || mode_ff > pds_pkg::POL_SRTF))) begin
                  have_ff <= 1'b1;
                  best_ff <= key;
                  pick_ff <= IW'(ptr_ff - CW'(1));
                  hold_ff <= rd_ff;
               end
               rd_vld_ff <= 1'b1;
               ptr_ff <= ptr_ff + CW'(1);
            end
            S_DEC: begin
               // The result is built here and raised once the table update is done.
               if (is_srtf && clk_ff != TMAX) clk_ff <= clk_ff + TIME_BITS'(1);
               if (!have_ff) begin
                  out_ff <= pack_out(pds_pkg::ST_IDLE, '0, '0, 1'b0, '0,
                     16'(is_srtf && clk_ff != TMAX ? clk_ff + TIME_BITS'(1) : clk_ff));
                  sh_ff <= count_ff;
                  rotate_ff <= 1'b0;
               end else begin
                  out_ff <= pack_out(pds_pkg::ST_RUN, hold_ff.id, 16'(run_t),
                     left_t == '0, 16'(left_t),
                     16'(is_srtf && clk_ff != TMAX ? clk_ff + TIME_BITS'(1) : clk_ff));
                  // A finished task is shifted out, an unfinished SRTF task is updated
                  // in place, and an unfinished RR task moves to the tail.
                  sh_ff <= (is_srtf && left_t != '0) ? count_ff : CW'(pick_ff);
                  rotate_ff <= !is_srtf && (left_t != '0);
                  hold_ff.lft <= left_t;
               end
            end
            S_SHIFT: begin
               sh_ff <= sh_ff + CW'(1);
            end
            default: begin
               outv_ff <= 1'b1;
               if (have_ff && hold_ff.lft == '0) count_ff <= count_ff - CW'(1);
            end
         endcase
      end
   end
endmodule
